// File: rtl/core/plp_pkg.sv
// Package: shared types, codes and constants of the pulse pileup synthesizer.
package plp_pkg;

	localparam int SHAPE_DEPTH_DEF = 1024;
	localparam int MAX_TRIG_DEF    = 7;

	localparam int SHAPE_W   = 16;
	localparam int INDEX_W   = 10;
	localparam int TRIG_W    = 3;
	localparam int NOISE_W   = 16;
	localparam int OUT_W     = 24;
	localparam int AMP_W     = 16;
	localparam int LEN_W     = 11;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int OUT_SHIFT = 8;

	localparam int OUT_MAX = 8388607;
	localparam int OUT_MIN = -8388608;

	localparam logic [AMP_W-1:0] AMP_RESET = 16'd256;
	localparam logic             POL_RESET = 1'b0;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	localparam logic [1:0] REG_AMPLITUDE    = 2'd0;
	localparam logic [1:0] REG_POLARITY     = 2'd1;
	localparam logic [1:0] REG_SHAPE_LENGTH = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_SCALE,
		ST_POLAR,
		ST_FINISH
	} plp_state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic rotate;
	} plp_chain_ctl_t;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude;
		logic             negative_polarity;
		logic [LEN_W-1:0] shape_length;
	} plp_cfg_t;

endpackage

// File: rtl/core/plp_if.sv
// Interfaces: input item channel and result channel with valid/ready handshake.
interface plp_in_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [plp_pkg::INDEX_W-1:0]         shape_index;
	logic signed [plp_pkg::SHAPE_W-1:0]  shape_value;
	logic [plp_pkg::TRIG_W-1:0]          trigger_count;
	logic signed [plp_pkg::NOISE_W-1:0]  noise_sample;

	modport source(output valid, kind, shape_index, shape_value, trigger_count, noise_sample,
		input ready);
	modport sink(input valid, kind, shape_index, shape_value, trigger_count, noise_sample,
		output ready);
endinterface

interface plp_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [plp_pkg::OUT_W-1:0]  sample_out;
	logic                              saturated;

	modport source(output valid, sample_out, saturated, input ready);
	modport sink(input valid, sample_out, saturated, output ready);
endinterface

// File: rtl/core/plp_cfg_regs.sv
// APB configuration registers: amplitude, polarity and shape length.
module plp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plp_pkg::PADDR_W-1:0]   paddr,
	input  logic [plp_pkg::PDATA_W-1:0]   pwdata,
	output logic [plp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output plp_pkg::plp_cfg_t             cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	plp_pkg::plp_cfg_t cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude         <= plp_pkg::AMP_RESET;
			cfg_q.negative_polarity <= plp_pkg::POL_RESET;
			cfg_q.shape_length      <= plp_pkg::LEN_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				plp_pkg::REG_AMPLITUDE:    cfg_q.amplitude         <= pwdata[plp_pkg::AMP_W-1:0];
				plp_pkg::REG_POLARITY:     cfg_q.negative_polarity <= pwdata[0];
				plp_pkg::REG_SHAPE_LENGTH: cfg_q.shape_length      <= pwdata[plp_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			plp_pkg::REG_AMPLITUDE:
				prdata = {{(plp_pkg::PDATA_W-plp_pkg::AMP_W){1'b0}}, cfg_q.amplitude};
			plp_pkg::REG_POLARITY:
				prdata = {{(plp_pkg::PDATA_W-1){1'b0}}, cfg_q.negative_polarity};
			plp_pkg::REG_SHAPE_LENGTH:
				prdata = {{(plp_pkg::PDATA_W-plp_pkg::LEN_W){1'b0}}, cfg_q.shape_length};
			default:
				prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/plp_cell.sv
// One chain cell: a trigger count and a shape word, shifted or rotated to neighbors.
module plp_cell #(
	parameter int CNT_W = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  plp_pkg::plp_chain_ctl_t             ctl,
	input  logic                                load_en,
	input  logic signed [plp_pkg::SHAPE_W-1:0]  load_value,
	input  logic [CNT_W-1:0]                    shift_in,
	input  logic [CNT_W-1:0]                    rot_hist_in,
	input  logic signed [plp_pkg::SHAPE_W-1:0]  rot_shape_in,
	output logic [CNT_W-1:0]                    hist,
	output logic signed [plp_pkg::SHAPE_W-1:0]  shape
);

	logic [CNT_W-1:0]                   hist_q;
	logic signed [plp_pkg::SHAPE_W-1:0] shape_q;

	assign hist  = hist_q;
	assign shape = shape_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctl.shift) begin
			hist_q <= shift_in;
		end else if (ctl.rotate) begin
			hist_q <= rot_hist_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			shape_q <= load_value;
		end else if (ctl.rotate) begin
			shape_q <= rot_shape_in;
		end
	end

endmodule

// File: rtl/core/plp_chain.sv
// Ring of cells: history shifts in on a tick, the whole ring rotates past the head.
module plp_chain #(
	parameter int DEPTH = plp_pkg::SHAPE_DEPTH_DEF,
	parameter int CNT_W = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  plp_pkg::plp_chain_ctl_t             ctl,
	input  logic [plp_pkg::INDEX_W-1:0]         load_index,
	input  logic signed [plp_pkg::SHAPE_W-1:0]  load_value,
	input  logic [CNT_W-1:0]                    new_count,
	output logic [CNT_W-1:0]                    head_hist,
	output logic signed [plp_pkg::SHAPE_W-1:0]  head_shape
);

	logic [CNT_W-1:0]                   hist_w      [DEPTH];
	logic signed [plp_pkg::SHAPE_W-1:0] shape_w     [DEPTH];
	logic [CNT_W-1:0]                   shift_src_w [DEPTH];
	logic                               load_en_w   [DEPTH];

	assign head_hist  = hist_w[0];
	assign head_shape = shape_w[0];

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		localparam int NXT = (k + 1) % DEPTH;

		if (k == 0) begin : g_head
			assign shift_src_w[k] = new_count;
		end else begin : g_body
			assign shift_src_w[k] = hist_w[k-1];
		end

		assign load_en_w[k] = ctl.load && (32'(load_index) == k);

		plp_cell #(
			.CNT_W(CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.load_en     (load_en_w[k]),
			.load_value  (load_value),
			.shift_in    (shift_src_w[k]),
			.rot_hist_in (hist_w[NXT]),
			.rot_shape_in(shape_w[NXT]),
			.hist        (hist_w[k]),
			.shape       (shape_w[k])
		);
	end

endmodule

// File: rtl/core/lut_pulse_pileup_synthesizer.sv
// Top level: pulse pileup synthesizer with cell ring, MAC, scaling and result register.
//
//  port     | dir | transaction
//  ---------+-----+------------------------------------------------------------
//  item     | in  | kind, shape_index, shape_value, trigger_count, noise_sample
//  result   | out | sample_out, saturated (one per tick, none per shape load)
//  apb      | in  | amplitude, negative_polarity, shape_length at 0x0/0x4/0x8
//
// A shape load writes one shape word of the ring. On a tick the ring of cells
// rotates once past a single MAC at its head, one cell per cycle, followed by
// gain, polarity and noise/saturation stages. One tick is in flight at a time.
// Reset clears the trigger history, the configuration and the result valid flag.
// A stalled result holds in the output register; the next item is taken meanwhile.
module lut_pulse_pileup_synthesizer #(
	parameter int SHAPE_DEPTH   = plp_pkg::SHAPE_DEPTH_DEF,
	parameter int MAX_TRIGGERS  = plp_pkg::MAX_TRIG_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	plp_in_if.sink                        item,
	plp_out_if.source                     result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plp_pkg::PADDR_W-1:0]   paddr,
	input  logic [plp_pkg::PDATA_W-1:0]   pwdata,
	output logic [plp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int CNT_W   = $clog2(MAX_TRIGGERS + 1);
	localparam int CMP_W   = (CNT_W > plp_pkg::TRIG_W) ? CNT_W : plp_pkg::TRIG_W;
	localparam int STEP_W  = $clog2(SHAPE_DEPTH);
	localparam int MPROD_W = CNT_W + plp_pkg::SHAPE_W + 1;
	localparam int ACC_W   = MPROD_W + STEP_W;
	localparam int PROD_W  = ACC_W + plp_pkg::AMP_W + 1;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SHAPE_DEPTH - 1);

	plp_pkg::plp_state_t     state_q, state_d;
	plp_pkg::plp_chain_ctl_t chain_ctl;
	plp_pkg::plp_cfg_t       cfg;

	logic                               in_acc;
	logic                               fin_load;
	logic [CMP_W-1:0]                   trig_ext;
	logic [CNT_W-1:0]                   trig_clamped;
	logic [CNT_W-1:0]                   head_hist;
	logic signed [plp_pkg::SHAPE_W-1:0] head_shape;
	logic signed [MPROD_W-1:0]          mac_prod;
	logic                               in_len;
	logic signed [PROD_W-1:0]           fin_sum;
	logic                               fin_hi;
	logic                               fin_lo;

	logic [STEP_W-1:0]                  step_q;
	logic signed [ACC_W-1:0]            acc_q;
	logic signed [plp_pkg::NOISE_W-1:0] noise_q;
	logic signed [PROD_W-1:0]           scale_s1;
	logic signed [PROD_W-1:0]           pol_s2;
	logic                               out_valid_q;
	logic signed [plp_pkg::OUT_W-1:0]   sample_q;
	logic                               sat_q;

	plp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign trig_ext     = CMP_W'(item.trigger_count);
	assign trig_clamped = (trig_ext > CMP_W'(MAX_TRIGGERS)) ? CNT_W'(MAX_TRIGGERS)
		: CNT_W'(trig_ext);

	plp_chain #(
		.DEPTH(SHAPE_DEPTH),
		.CNT_W(CNT_W)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (chain_ctl),
		.load_index(item.shape_index),
		.load_value(item.shape_value),
		.new_count (trig_clamped),
		.head_hist (head_hist),
		.head_shape(head_shape)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plp_pkg::ST_IDLE:   if (item.valid && item.kind == plp_pkg::KIND_TICK) begin
				state_d = plp_pkg::ST_RUN;
			end
			plp_pkg::ST_RUN:    if (step_q == STEP_LAST) begin
				state_d = plp_pkg::ST_SCALE;
			end
			plp_pkg::ST_SCALE:  state_d = plp_pkg::ST_POLAR;
			plp_pkg::ST_POLAR:  state_d = plp_pkg::ST_FINISH;
			plp_pkg::ST_FINISH: if (!out_valid_q || result.ready) begin
				state_d = plp_pkg::ST_IDLE;
			end
			default:            state_d = plp_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item.ready       = (state_q == plp_pkg::ST_IDLE);
		in_acc           = item.valid && item.ready;
		chain_ctl.load   = in_acc && (item.kind == plp_pkg::KIND_LOAD);
		chain_ctl.shift  = in_acc && (item.kind == plp_pkg::KIND_TICK);
		chain_ctl.rotate = (state_q == plp_pkg::ST_RUN);
		fin_load         = (state_q == plp_pkg::ST_FINISH) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plp_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (chain_ctl.rotate) begin
				step_q <= (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
			end
		end
	end

	// MAC at the ring head
	assign mac_prod = $signed({1'b0, head_hist}) * head_shape;
	assign in_len   = 32'(step_q) < 32'(cfg.shape_length);

	always_ff @(posedge clk) begin
		if (chain_ctl.shift) begin
			acc_q   <= '0;
			noise_q <= item.noise_sample;
		end else if (chain_ctl.rotate && in_len) begin
			acc_q <= acc_q + ACC_W'(mac_prod);
		end
		if (state_q == plp_pkg::ST_SCALE) begin
			scale_s1 <= acc_q * $signed({1'b0, cfg.amplitude});
		end
		if (state_q == plp_pkg::ST_POLAR) begin
			pol_s2 <= cfg.negative_polarity ? -scale_s1 : scale_s1;
		end
	end

	// noise add and saturation
	always_comb begin
		fin_sum = (pol_s2 >>> plp_pkg::OUT_SHIFT) + PROD_W'(noise_q);
		fin_hi  = fin_sum > PROD_W'(plp_pkg::OUT_MAX);
		fin_lo  = fin_sum < PROD_W'(plp_pkg::OUT_MIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			sample_q <= fin_hi ? plp_pkg::OUT_W'(plp_pkg::OUT_MAX)
				: fin_lo ? plp_pkg::OUT_W'(plp_pkg::OUT_MIN)
				: fin_sum[plp_pkg::OUT_W-1:0];
			sat_q    <= fin_hi || fin_lo;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = sample_q;
	assign result.saturated  = sat_q;

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plp_pkg::ST_IDLE) |-> (step_q == '0))
		else $error("step counter not parked while idle");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.kind == plp_pkg::KIND_LOAD)
		|=> (state_q == plp_pkg::ST_IDLE))
		else $error("shape load left idle");

	a_tick_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.kind == plp_pkg::KIND_TICK)
		|=> (state_q == plp_pkg::ST_RUN))
		else $error("tick did not start rotation");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == plp_pkg::ST_FINISH))
		else $error("result raised outside finish");

endmodule

// File: dv/lut_pulse_pileup_synthesizer_tb.sv
// Testbench: lut_pulse_pileup_synthesizer checked against its own waveform predictor.
`timescale 1ns / 1ps

module lut_pulse_pileup_synthesizer_tb;

	localparam int SHAPE_DEPTH = plp_pkg::SHAPE_DEPTH_DEF;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 85;
	localparam int LONG_HOLD   = 5000;
	localparam int LIMIT       = 40000000;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic                               kind;
		logic [plp_pkg::INDEX_W-1:0]        shape_index;
		logic signed [plp_pkg::SHAPE_W-1:0] shape_value;
		logic [plp_pkg::TRIG_W-1:0]         trigger_count;
		logic signed [plp_pkg::NOISE_W-1:0] noise_sample;
	} plp_item_t;

	typedef struct packed {
		logic signed [plp_pkg::OUT_W-1:0] sample;
		logic                             sat;
	} wave_sample_t;

	typedef enum logic {STEP_ITEM, STEP_REG} step_kind_t;

	typedef struct {
		step_kind_t   op;
		plp_item_t    it;
		bit           typed;
		wave_sample_t want;
		logic [1:0]   ridx;
		logic [31:0]  data;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [plp_pkg::PADDR_W-1:0] paddr;
	logic [plp_pkg::PDATA_W-1:0] pwdata;
	logic [plp_pkg::PDATA_W-1:0] prdata;
	logic pready;

	plp_in_if  item_ch ();
	plp_out_if result_ch ();

	lut_pulse_pileup_synthesizer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	logic signed [plp_pkg::SHAPE_W-1:0] shape_mirror [SHAPE_DEPTH];
	logic [plp_pkg::TRIG_W-1:0]         trigger_ring [SHAPE_DEPTH];
	logic [plp_pkg::INDEX_W-1:0]        ring_head;
	plp_pkg::plp_cfg_t                  cfg_shadow;

	wave_sample_t expected_samples [$];
	dir_row_t     plan [$];

	int  errors;
	int  ticks_sent;
	int  loads_sent;
	int  samples_checked;
	int  clipped_seen;
	int  long_holds;
	int  burst_left;
	int  run_cycles;
	bit  hold_requested;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		run_cycles++;
		if (run_cycles > LIMIT) begin
			$display("%0t: timeout, %0d samples still pending", $time, expected_samples.size());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void predict_waveform(input plp_item_t it, output bit produced,
		output wave_sample_t res);
		longint acc;
		longint v;
		int len;
		logic [plp_pkg::INDEX_W-1:0] pos;
		produced = 1'b0;
		res = '0;
		if (it.kind == plp_pkg::KIND_LOAD) begin
			shape_mirror[it.shape_index] = it.shape_value;
			return;
		end
		ring_head = ring_head + 1'b1;
		trigger_ring[ring_head] = it.trigger_count;
		len = (int'(cfg_shadow.shape_length) > SHAPE_DEPTH) ? SHAPE_DEPTH :
			int'(cfg_shadow.shape_length);
		acc = 0;
		for (int k = 0; k < len; k++) begin
			pos = ring_head - plp_pkg::INDEX_W'(k);
			acc += longint'(trigger_ring[pos]) * longint'(shape_mirror[k]);
		end
		v = acc * longint'(cfg_shadow.amplitude);
		if (cfg_shadow.negative_polarity)
			v = -v;
		v = (v >>> plp_pkg::OUT_SHIFT) + longint'(it.noise_sample);
		if (v > plp_pkg::OUT_MAX) begin
			v = plp_pkg::OUT_MAX;
			res.sat = 1'b1;
		end else if (v < plp_pkg::OUT_MIN) begin
			v = plp_pkg::OUT_MIN;
			res.sat = 1'b1;
		end
		res.sample = v[plp_pkg::OUT_W-1:0];
		produced = 1'b1;
	endfunction

	function automatic plp_item_t tick_item(logic [plp_pkg::TRIG_W-1:0] trig,
		logic signed [plp_pkg::NOISE_W-1:0] noise);
		plp_item_t it;
		it.kind          = plp_pkg::KIND_TICK;
		it.shape_index   = plp_pkg::INDEX_W'($urandom);
		it.shape_value   = plp_pkg::SHAPE_W'($urandom);
		it.trigger_count = trig;
		it.noise_sample  = noise;
		return it;
	endfunction

	function automatic plp_item_t load_item(logic [plp_pkg::INDEX_W-1:0] idx,
		logic signed [plp_pkg::SHAPE_W-1:0] val);
		plp_item_t it;
		it.kind          = plp_pkg::KIND_LOAD;
		it.shape_index   = idx;
		it.shape_value   = val;
		it.trigger_count = plp_pkg::TRIG_W'($urandom);
		it.noise_sample  = plp_pkg::NOISE_W'($urandom);
		return it;
	endfunction

	function automatic plp_item_t rand_item();
		plp_item_t it;
		it = tick_item(plp_pkg::TRIG_W'($urandom), plp_pkg::NOISE_W'($urandom));
		it.kind = 1'($urandom);
		return it;
	endfunction

	function automatic dir_row_t step_item(plp_item_t it, bit typed, int sample, bit sat);
		dir_row_t r;
		r.op          = STEP_ITEM;
		r.it          = it;
		r.typed       = typed;
		r.want.sample = plp_pkg::OUT_W'(sample);
		r.want.sat    = sat;
		r.ridx        = '0;
		r.data        = '0;
		return r;
	endfunction

	function automatic dir_row_t step_reg(logic [1:0] ridx, logic [31:0] data);
		dir_row_t r;
		r.op    = STEP_REG;
		r.it    = '0;
		r.typed = 1'b0;
		r.want  = '0;
		r.ridx  = ridx;
		r.data  = data;
		return r;
	endfunction

	task automatic offer(plp_item_t it, bit typed, wave_sample_t want);
		bit produced;
		wave_sample_t predicted;
		item_ch.valid         <= 1'b1;
		item_ch.kind          <= it.kind;
		item_ch.shape_index   <= it.shape_index;
		item_ch.shape_value   <= it.shape_value;
		item_ch.trigger_count <= it.trigger_count;
		item_ch.noise_sample  <= it.noise_sample;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		predict_waveform(it, produced, predicted);
		if (produced)
			expected_samples.push_back(typed ? want : predicted);
		if (it.kind == plp_pkg::KIND_LOAD)
			loads_sent++;
		else
			ticks_sent++;
	endtask

	// sender bursts and gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1100) : $urandom_range(0, 12);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) :
				$urandom_range(1, 20);
		end
	endtask

	// drain: loads give no result, so allow a full tick time after the last sample
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SHAPE_DEPTH + 8) @(posedge clk);
	endtask

	task automatic apb_access(logic [1:0] ridx, bit wr, logic [31:0] data,
		output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {ridx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] ridx, logic [31:0] data);
		logic [31:0] rd;
		logic [31:0] want;
		apb_access(ridx, 1'b1, data, rd);
		case (ridx)
			plp_pkg::REG_AMPLITUDE:    cfg_shadow.amplitude = data[plp_pkg::AMP_W-1:0];
			plp_pkg::REG_POLARITY:     cfg_shadow.negative_polarity = data[0];
			plp_pkg::REG_SHAPE_LENGTH: cfg_shadow.shape_length = data[plp_pkg::LEN_W-1:0];
			default: ;
		endcase
		if (ridx != REG_UNMAPPED) begin
			case (ridx)
				plp_pkg::REG_AMPLITUDE: want = 32'(cfg_shadow.amplitude);
				plp_pkg::REG_POLARITY:  want = 32'(cfg_shadow.negative_polarity);
				default:                want = 32'(cfg_shadow.shape_length);
			endcase
			apb_access(ridx, 1'b0, '0, rd);
			if (rd !== want) begin
				$display("%0t: readback of register %0d: expected %0h, got %0h",
					$time, ridx, want, rd);
				errors++;
			end
		end
	endtask

	initial begin : result_sink
		int seg_left;
		int mode;
		int sink_tick;
		seg_left  = 0;
		mode      = 0;
		sink_tick = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			sink_tick++;
			if (hold_requested) begin
				hold_requested = 1'b0;
				long_holds++;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				result_ch.ready <= 1'b1;
				seg_left = 0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					case (mode)
						0:       seg_left = $urandom_range(1, 3000);
						1:       seg_left = $urandom_range(1, 500);
						2:       seg_left = $urandom_range(1, 1500);
						default: seg_left = $urandom_range(1, 2000);
					endcase
				end
				seg_left--;
				case (mode)
					0:       result_ch.ready <= 1'b1;
					1:       result_ch.ready <= 1'($urandom);
					2:       result_ch.ready <= 1'b0;
					default: result_ch.ready <= (sink_tick[3:2] != 2'b00);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		wave_sample_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample: expected none, got %0d sat %0b",
					$time, result_ch.sample_out, result_ch.saturated);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				samples_checked++;
				if (want.sat)
					clipped_seen++;
				if (result_ch.sample_out !== want.sample) begin
					$display("%0t: sample_out mismatch: expected %0d, got %0d",
						$time, want.sample, result_ch.sample_out);
					errors++;
				end
				if (result_ch.saturated !== want.sat) begin
					$display("%0t: saturated mismatch: expected %0b, got %0b",
						$time, want.sat, result_ch.saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [31:0] amp;
		logic [31:0] pol;
		logic [31:0] len;
		logic signed [plp_pkg::SHAPE_W-1:0] val;
		int sent;
		int n;
		int start;
		int pick;

		arst_n                <= 1'b0;
		item_ch.valid         <= 1'b0;
		item_ch.kind          <= plp_pkg::KIND_LOAD;
		item_ch.shape_index   <= '0;
		item_ch.shape_value   <= '0;
		item_ch.trigger_count <= '0;
		item_ch.noise_sample  <= '0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		for (int k = 0; k < SHAPE_DEPTH; k++) begin
			shape_mirror[k] = '0;
			trigger_ring[k] = '0;
		end
		ring_head                    = '0;
		cfg_shadow.amplitude         = plp_pkg::AMP_RESET;
		cfg_shadow.negative_polarity = plp_pkg::POL_RESET;
		cfg_shadow.shape_length      = plp_pkg::LEN_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole shape store written before any tick reads it
		for (int k = 0; k < SHAPE_DEPTH; k++) begin
			case (k)
				0:       val = 16'sh7FFF;
				1:       val = -16'sh8000;
				2:       val = 16'sd1;
				default: val = plp_pkg::SHAPE_W'($urandom);
			endcase
			offer(load_item(plp_pkg::INDEX_W'(k), val), 1'b0, '0);
			pace();
		end

		plan = {
			step_item(tick_item(3'd0, 16'sh7FFF), 1'b1, 32767, 1'b0),
			step_item(tick_item(3'd0, -16'sh8000), 1'b1, -32768, 1'b0),
			step_item(tick_item(3'd0, 16'sd0), 1'b1, 0, 1'b0),
			step_reg(plp_pkg::REG_SHAPE_LENGTH, 32'd1),
			step_item(tick_item(3'd7, 16'sd0), 1'b0, 0, 1'b0),
			step_reg(plp_pkg::REG_AMPLITUDE, 32'd65535),
			step_item(tick_item(3'd7, 16'sh7FFF), 1'b1, plp_pkg::OUT_MAX, 1'b1),
			step_reg(plp_pkg::REG_POLARITY, 32'd1),
			step_item(tick_item(3'd7, -16'sh8000), 1'b1, plp_pkg::OUT_MIN, 1'b1),
			step_reg(plp_pkg::REG_SHAPE_LENGTH, 32'd2),
			step_item(tick_item(3'd7, 16'sd0), 1'b0, 0, 1'b0),
			step_reg(REG_UNMAPPED, 32'hFFFF_FFFF),
			step_item(tick_item(3'd1, 16'sd100), 1'b0, 0, 1'b0),
			step_reg(plp_pkg::REG_SHAPE_LENGTH, 32'd0),
			step_item(tick_item(3'd5, 16'sd1234), 1'b1, 1234, 1'b0),
			step_reg(plp_pkg::REG_SHAPE_LENGTH, 32'd2047),
			step_item(tick_item(3'd3, -16'sd5), 1'b0, 0, 1'b0),
			step_reg(plp_pkg::REG_AMPLITUDE, 32'd0),
			step_item(tick_item(3'd7, -16'sd1), 1'b1, -1, 1'b0),
			step_reg(plp_pkg::REG_AMPLITUDE, 32'd1),
			step_item(load_item(10'd1023, -16'sd1), 1'b0, 0, 1'b0),
			step_item(load_item(10'd0, 16'sd0), 1'b0, 0, 1'b0),
			step_item(tick_item(3'd7, 16'sd0), 1'b0, 0, 1'b0),
			step_item(tick_item(3'd0, 16'sd0), 1'b0, 0, 1'b0),
			step_reg(plp_pkg::REG_POLARITY, 32'd0),
			step_reg(plp_pkg::REG_AMPLITUDE, 32'd256),
			step_reg(plp_pkg::REG_SHAPE_LENGTH, 32'd1024),
			step_item(tick_item(3'd2, -16'sh8000), 1'b0, 0, 1'b0)
		};
		foreach (plan[i]) begin
			if (plan[i].op == STEP_REG) begin
				settle();
				write_reg(plan[i].ridx, plan[i].data);
			end else begin
				offer(plan[i].it, plan[i].typed, plan[i].want);
				pace();
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin amp = 32'd65535; pol = 32'd0; len = 32'd1024; end
				1: begin amp = 32'd1;     pol = 32'd1; len = 32'd1;    end
				2: begin amp = 32'd256;   pol = 32'd0; len = 32'd2047; end
				3: begin amp = 32'd65535; pol = 32'd1; len = 32'd16;   end
				default: begin
					amp = $urandom;
					pol = $urandom_range(0, 1);
					case ($urandom_range(0, 5))
						0:       len = 32'd0;
						1:       len = 32'd1;
						2:       len = $urandom_range(2, 32);
						3:       len = $urandom_range(1, SHAPE_DEPTH);
						4:       len = SHAPE_DEPTH;
						default: len = $urandom_range(SHAPE_DEPTH + 1, 2047);
					endcase
				end
			endcase
			settle();
			write_reg(plp_pkg::REG_AMPLITUDE, amp);
			write_reg(plp_pkg::REG_POLARITY, pol);
			write_reg(plp_pkg::REG_SHAPE_LENGTH, len);
			if (ph == 2)
				hold_requested = 1'b1;

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					n = $urandom_range(1, 4);
					repeat (n) begin
						offer(rand_item(), 1'b0, '0);
						pace();
					end
					sent += n;
				end else if (pick == 1) begin
					// shape rewrite with no pulse train behind it
					n = $urandom_range(1, 6);
					start = $urandom_range(0, SHAPE_DEPTH - 1);
					for (int j = 0; j < n; j++) begin
						offer(load_item(plp_pkg::INDEX_W'(start + j),
							plp_pkg::SHAPE_W'($urandom)), 1'b0, '0);
						pace();
					end
					sent += n;
				end else begin
					if ($urandom_range(0, 1) == 1) begin
						n = $urandom_range(1, 16);
						start = $urandom_range(0, 31);
						for (int j = 0; j < n; j++) begin
							offer(load_item(plp_pkg::INDEX_W'(start + j),
								plp_pkg::SHAPE_W'($urandom)), 1'b0, '0);
							pace();
						end
						sent += n;
					end
					n = $urandom_range(4, 20);
					for (int j = 0; j < n; j++) begin
						offer(tick_item(($urandom_range(0, 3) == 0) ?
							plp_pkg::TRIG_W'($urandom_range(1, 7)) : plp_pkg::TRIG_W'(0),
							($urandom_range(0, 1) == 1) ?
							plp_pkg::NOISE_W'($urandom_range(0, 63) - 32) :
							plp_pkg::NOISE_W'($urandom)),
							1'b0, '0);
						pace();
					end
					sent += n;
				end
			end
		end

		item_ch.valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SHAPE_DEPTH + 16) @(posedge clk);
		$display("Covered %0d shape loads and %0d ticks over %0d settings, %0d long output stalls.",
			loads_sent, ticks_sent, PHASES + 1, long_holds);
		$display("Checked %0d waveform samples, %0d of them clipped.", samples_checked,
			clipped_seen);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
